/* rtl/core/cabg_pkg.sv */
package cabg_pkg;

   // automaton geometry
   localparam int NUM_WORDS   = 80;
   localparam int EXT_WORDS   = 52;
   localparam int SEED_BYTES  = 640;
   localparam int SEED_ROUNDS = 197;
   localparam int WORD_STEP   = 4;
   localparam int WORD_W      = 64;
   localparam int BYTE_W      = 8;

   // shuffle taps into the extended word array
   localparam int TAP_0 = 0;
   localparam int TAP_1 = 5;
   localparam int TAP_2 = 12;
   localparam int TAP_3 = 29;
   localparam int TAP_4 = EXT_WORDS;

   localparam int IDX_W     = $clog2(NUM_WORDS);
   localparam int MEM_DEPTH = 2 * NUM_WORDS;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int CNT_W     = $clog2(WORD_W + 1);
   localparam int POS_W     = $clog2(SEED_BYTES);
   localparam int LANE_W    = $clog2(WORD_W / BYTE_W);
   localparam int ROUND_W   = $clog2(SEED_ROUNDS + 1);

   // stream payload widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;

   // command codes
   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_SEED = 1'b1;

   typedef enum logic [2:0] {
      UNIT_NONE,
      UNIT_MIX_X,
      UNIT_MIX_O,
      UNIT_MIX_END,
      UNIT_SEED,
      UNIT_TAKE
   } unit_op_type;

   typedef struct packed {
      unit_op_type      op;
      logic             rot_a;
      logic             rot_b;
      logic [CNT_W-1:0] amount;
   } unit_ctl_type;

   typedef struct packed {
      logic             wrap;
      logic [IDX_W-1:0] idx;
   } ext_src_type;

   localparam logic [WORD_W-1:0] INIT_TABLE [NUM_WORDS] = '{
      64'ha888f71022e181bd, 64'h2385a85e36087989, 64'h20ff49270ec954cf, 64'ha68f432825ff749b,
      64'h87bfabfaee5c4d9e, 64'h0fc0d678d213f99c, 64'h439271a5c7c22777, 64'habe5acb9642a8103,
      64'h5c17a5228613598d, 64'h89de293826b2a148, 64'h4454535aec23e7c6, 64'h7226cb254a47cbc6,
      64'hba8b66c3835aad7e, 64'hfb59214b81d4a98c, 64'he62dc0746ad746be, 64'hd1f4194ecb6cd9d5,
      64'h78701f81f42c1948, 64'h8fccc9aaea1b68e9, 64'h464adfa0a258c07d, 64'h0f1f3ed907b3c47d,
      64'h8dec694af72add42, 64'hbfee489c7e8ef175, 64'hbfa60a9c4435876e, 64'h0452d611c7f055da,
      64'h8c8f3854e3fa1448, 64'h9e83bfb8c0b0e837, 64'ha942abdb2d91d070, 64'h6f52de0bf1e47693,
      64'h34c4d38ad1212667, 64'h4b06768ef21391bd, 64'h8e1412e997c9a8fd, 64'h50bfda09377ea28a,
      64'h078800b5470871ea, 64'ha9aaa916da96c5fb, 64'h22152498eca9c50a, 64'h6c51da24b87250b0,
      64'h1d46e78f65a2ef55, 64'h2da0d6c791de8be7, 64'h90295517bc846686, 64'h998a54e3218ac814,
      64'hd3ec5836257b96f8, 64'h19908f7cac6a00f5, 64'hfaa481ec4c16019c, 64'h97e6398dd5dee075,
      64'h48475ccfba79d982, 64'hd6a1062d4f3bcd4c, 64'h87a0959ece65f509, 64'h6719e57ed6ede60d,
      64'hf648daa575d9c6f7, 64'he5bb2da9c118e114, 64'haaebc6474fc5a834, 64'h874dcaf472a76dfc,
      64'h56309d44ddfa7109, 64'h9001cac5d3254553, 64'ha46727129321f695, 64'h357e1feae487b4b8,
      64'hdf6d1e1461a5876f, 64'h36fe3f03e1620147, 64'h3bb292e092dbec1e, 64'h04b054997f76a743,
      64'hd4629048376cb213, 64'h06f9bcb003bf6f82, 64'h5d36b34645d974d9, 64'h91a12bd764896c61,
      64'h6646abd7f82ff67f, 64'h90447798b42b05c7, 64'hbc10e5e87050f778, 64'h9ab994748afd5155,
      64'h05fe8ae3c32bb299, 64'hdfd34d860ea09cca, 64'hb99a9896a7dc966d, 64'h9f12f07a7dbb9ec7,
      64'he1a3bb6258d768e0, 64'h8a580cc45515cf7d, 64'h160c96cc71849d40, 64'h66c6624197f3d708,
      64'hb1acb50934546050, 64'hae0236b997921d2a, 64'hf632a828b5ef628e, 64'h14e8210276047ffa
   };

   // shifts by the full word width or more give zero
   function automatic logic [WORD_W-1:0] shl_word(input logic [WORD_W-1:0] v,
                                                  input logic [CNT_W-1:0] s);
      logic [WORD_W-1:0] r;
      r = '0;
      if (s < CNT_W'(WORD_W)) r = v << s;
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] shr_word(input logic [WORD_W-1:0] v,
                                                  input logic [CNT_W-1:0] s);
      logic [WORD_W-1:0] r;
      r = '0;
      if (s < CNT_W'(WORD_W)) r = v >> s;
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] v);
      return {v[WORD_W-2:0], v[WORD_W-1]};
   endfunction

   // extended index idx+off folds back onto the low words with a rotate
   function automatic ext_src_type ext_src(input logic [IDX_W-1:0] idx, input int off);
      logic [IDX_W:0] j;
      ext_src_type    s;
      j      = {1'b0, idx} + (IDX_W+1)'(off);
      s.wrap = (j >= (IDX_W+1)'(NUM_WORDS));
      s.idx  = s.wrap ? IDX_W'(j - (IDX_W+1)'(NUM_WORDS)) : j[IDX_W-1:0];
      return s;
   endfunction

   // two banks of words back to back in one memory
   function automatic logic [MEM_AW-1:0] mem_addr(input logic bank, input logic [IDX_W-1:0] idx);
      logic [MEM_AW-1:0] a;
      a = MEM_AW'(idx);
      if (bank) a = a + MEM_AW'(NUM_WORDS);
      return a;
   endfunction

endpackage

/* rtl/core/cabg_mem.sv */
module cabg_mem (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [cabg_pkg::MEM_AW-1:0]   wr_addr,
   input  logic [cabg_pkg::WORD_W-1:0]   wr_data,
   input  logic [cabg_pkg::MEM_AW-1:0]   rd_addr_a,
   output logic [cabg_pkg::WORD_W-1:0]   rd_data_a,
   input  logic [cabg_pkg::MEM_AW-1:0]   rd_addr_b,
   output logic [cabg_pkg::WORD_W-1:0]   rd_data_b
);
   import cabg_pkg::*;

   logic [WORD_W-1:0] mem_ff [MEM_DEPTH];
   logic [WORD_W-1:0] rd_data_a_ff;
   logic [WORD_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* rtl/core/cabg_unit.sv */
module cabg_unit (
   input  cabg_pkg::unit_ctl_type        ctl,
   input  logic [cabg_pkg::WORD_W-1:0]   rd_a,
   input  logic [cabg_pkg::WORD_W-1:0]   rd_b,
   input  logic [cabg_pkg::WORD_W-1:0]   acc_x,
   input  logic [cabg_pkg::WORD_W-1:0]   acc_o,
   input  logic [cabg_pkg::WORD_W-1:0]   val_in,
   input  logic [cabg_pkg::BYTE_W-1:0]   seed_byte,
   output logic [cabg_pkg::WORD_W-1:0]   word_out,
   output logic [cabg_pkg::WORD_W-1:0]   val_out
);
   import cabg_pkg::*;

   logic [WORD_W-1:0] ext_a;
   logic [WORD_W-1:0] ext_b;
   logic [LANE_W-1:0] lane;

   assign ext_a = ctl.rot_a ? rotl1(rd_a) : rd_a;
   assign ext_b = ctl.rot_b ? rotl1(rd_b) : rd_b;
   // byte lane rides in the low amount bits
   assign lane  = ctl.amount[LANE_W-1:0];

   always_comb begin
      word_out = '0;
      val_out  = '0;
      case (ctl.op)
         UNIT_MIX_X:   word_out = ext_a ^ ext_b;
         UNIT_MIX_O:   word_out = ext_a | ext_b;
         UNIT_MIX_END: word_out = ~((acc_o | ext_a) ^ acc_x);
         UNIT_SEED:    word_out = rd_a ^ (WORD_W'(seed_byte) << {lane, 3'b000});
         UNIT_TAKE: begin
            word_out = shl_word(rd_a, ctl.amount);
            val_out  = shl_word(val_in, ctl.amount)
                     | shr_word(rd_a, CNT_W'(WORD_W) - ctl.amount);
         end
         default: begin
            word_out = '0;
            val_out  = '0;
         end
      endcase
   end

endmodule

/* rtl/core/cellular_automaton_bit_generator.sv */
// draw: the word in use is read, its top bits taken and the result emitted; a draw that
// spans into the next word reads that one too, and one that starts on a used-up word first
// steps on; one item at a time. shuffle: phases SH0, SH1 and SH2 per word, then a tail write,
// paid by the draw that first needs a bit past the 20th word
// seed: first byte of a run first refills the table, later bytes only xor into their word, the last adds
// 197 shuffles (one for an empty seed); reset: synchronous, runs the fill and one shuffle before req_tready
module cellular_automaton_bit_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cabg_pkg::REQ_DATA_W-1:0]   req_tdata,  // bit_count[6:0], seed_byte[14:7], zero
   input  logic [cabg_pkg::REQ_USER_W-1:0]   req_tuser,  // cmd[0], seed_empty[1]
   input  logic                              req_tlast,  // seed_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cabg_pkg::WORD_W-1:0]       rsp_tdata   // random_value[63:0]
);
   import cabg_pkg::*;

   typedef enum logic [3:0] {
      S_FILL,
      S_IDLE,
      S_SEED_RD,
      S_SEED_WR,
      S_SH0,
      S_SH1,
      S_SH2,
      S_SH_TAIL,
      S_DRAW_RD,
      S_DRAW_TAKE,
      S_EMIT
   } state_type;

   state_type            state_ff,   state_in;
   logic                 bank_ff,    bank_in;     // which half of the memory holds the state
   logic [IDX_W-1:0]     wp_ff,      wp_in;       // word in use for draws
   logic [CNT_W-1:0]     br_ff,      br_in;       // unused bits in that word
   logic [POS_W-1:0]     sp_ff,      sp_in;       // next seed byte position
   logic                 seeding_ff, seeding_in;
   logic [IDX_W-1:0]     idx_ff,     idx_in;      // fill / shuffle word index
   logic [ROUND_W-1:0]   rounds_ff,  rounds_in;   // shuffles still to run
   logic                 rot_a_ff,   rot_a_in;    // read in flight comes from a folded tap
   logic                 rot_b_ff,   rot_b_in;
   logic                 cmd_ff,     cmd_in;
   logic                 last_ff,    last_in;
   logic                 empty_ff,   empty_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;

   // payload registers
   logic [CNT_W-1:0]     need_ff,    need_in;     // bits still owed to the draw
   logic [BYTE_W-1:0]    byte_ff,    byte_in;
   logic [WORD_W-1:0]    val_ff,     val_in;      // draw result being built
   logic [WORD_W-1:0]    x_ff,       x_in;        // xor of taps 0 and 1
   logic [WORD_W-1:0]    o_ff,       o_in;        // or of taps 2 and 3
   logic [WORD_W-1:0]    rsp_tdata_ff, rsp_tdata_in;

   // memory and unit hookup
   logic                 wr_en;
   logic [MEM_AW-1:0]    wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic [MEM_AW-1:0]    rd_addr_a;
   logic [MEM_AW-1:0]    rd_addr_b;
   logic [WORD_W-1:0]    rd_data_a;
   logic [WORD_W-1:0]    rd_data_b;
   unit_ctl_type         unit_ctl;
   logic [WORD_W-1:0]    unit_word;
   logic [WORD_W-1:0]    unit_val;

   // shuffle taps for the current word
   ext_src_type          src0, src1, src2, src3, src4;
   logic [CNT_W-1:0]     take_k;
   logic [IDX_W-1:0]     wp_next;
   logic [CNT_W-1:0]     req_count;

   assign src0 = ext_src(idx_ff, TAP_0);
   assign src1 = ext_src(idx_ff, TAP_1);
   assign src2 = ext_src(idx_ff, TAP_2);
   assign src3 = ext_src(idx_ff, TAP_3);
   assign src4 = ext_src(idx_ff, TAP_4);

   // bits taken from the current word in one step
   assign take_k    = (need_ff < br_ff) ? need_ff : br_ff;
   assign wp_next   = wp_ff + IDX_W'(WORD_STEP);
   assign req_count = req_tdata[CNT_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   cabg_mem u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   cabg_unit u_unit (
      .ctl       (unit_ctl),
      .rd_a      (rd_data_a),
      .rd_b      (rd_data_b),
      .acc_x     (x_ff),
      .acc_o     (o_ff),
      .val_in    (val_ff),
      .seed_byte (byte_ff),
      .word_out  (unit_word),
      .val_out   (unit_val)
   );

   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      wp_in         = wp_ff;
      br_in         = br_ff;
      sp_in         = sp_ff;
      seeding_in    = seeding_ff;
      idx_in        = idx_ff;
      rounds_in     = rounds_ff;
      rot_a_in      = rot_a_ff;
      rot_b_in      = rot_b_ff;
      cmd_in        = cmd_ff;
      last_in       = last_ff;
      empty_in      = empty_ff;
      need_in       = need_ff;
      byte_in       = byte_ff;
      val_in        = val_ff;
      x_in          = x_ff;
      o_in          = o_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;

      wr_en           = 1'b0;
      wr_addr         = mem_addr(bank_ff, idx_ff);
      wr_data         = unit_word;
      rd_addr_a       = '0;
      rd_addr_b       = '0;
      unit_ctl.op     = UNIT_NONE;
      unit_ctl.rot_a  = rot_a_ff;
      unit_ctl.rot_b  = rot_b_ff;
      unit_ctl.amount = '0;

      case (state_ff)
         // copy the constant table into the live bank
         S_FILL: begin
            wr_en   = 1'b1;
            wr_data = INIT_TABLE[idx_ff];
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(NUM_WORDS - 1)) begin
               idx_in = '0;
               // reset comes through here as an empty seed
               if (last_ff && empty_ff) begin
                  rounds_in  = ROUND_W'(1);
                  seeding_in = 1'b0;
                  state_in   = S_SH0;
               end else begin
                  state_in = S_SEED_RD;
               end
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser[0];
               last_in  = req_tlast;
               empty_in = req_tuser[1];
               byte_in  = req_tdata[CNT_W +: BYTE_W];
               val_in   = '0;
               if (req_tuser[0] == CMD_DRAW) begin
                  // zero count answers zero and touches nothing
                  if (req_count == '0) begin
                     state_in = S_EMIT;
                  end else begin
                     need_in  = (req_count > CNT_W'(WORD_W)) ? CNT_W'(WORD_W) : req_count;
                     state_in = S_DRAW_RD;
                  end
               end else if (!seeding_ff) begin
                  // first byte of a run restores the table
                  wp_in      = '0;
                  br_in      = CNT_W'(WORD_W);
                  sp_in      = '0;
                  seeding_in = 1'b1;
                  idx_in     = '0;
                  state_in   = S_FILL;
               end else if (req_tlast && req_tuser[1]) begin
                  // empty marker after real bytes still gets the full rounds
                  rounds_in  = ROUND_W'(SEED_ROUNDS);
                  seeding_in = 1'b0;
                  idx_in     = '0;
                  state_in   = S_SH0;
               end else begin
                  state_in = S_SEED_RD;
               end
            end
         end

         S_SEED_RD: begin
            rd_addr_a = mem_addr(bank_ff, sp_ff[POS_W-1:LANE_W]);
            state_in  = S_SEED_WR;
         end

         S_SEED_WR: begin
            unit_ctl.op     = UNIT_SEED;
            unit_ctl.amount = CNT_W'(sp_ff[LANE_W-1:0]);
            wr_en           = 1'b1;
            wr_addr         = mem_addr(bank_ff, sp_ff[POS_W-1:LANE_W]);
            sp_in           = (sp_ff == POS_W'(SEED_BYTES - 1)) ? '0 : sp_ff + 1'b1;
            if (last_ff) begin
               rounds_in  = ROUND_W'(SEED_ROUNDS);
               seeding_in = 1'b0;
               idx_in     = '0;
               state_in   = S_SH0;
            end else begin
               state_in = S_IDLE;
            end
         end

         // phase 0: finish the previous word, read taps 0 and 1
         S_SH0: begin
            unit_ctl.op = UNIT_MIX_END;
            wr_en       = (idx_ff != '0);
            wr_addr     = mem_addr(~bank_ff, idx_ff - 1'b1);
            rd_addr_a   = mem_addr(bank_ff, src0.idx);
            rd_addr_b   = mem_addr(bank_ff, src1.idx);
            rot_a_in    = src0.wrap;
            rot_b_in    = src1.wrap;
            state_in    = S_SH1;
         end

         // phase 1: fold taps 0 and 1, read taps 2 and 3
         S_SH1: begin
            unit_ctl.op = UNIT_MIX_X;
            x_in        = unit_word;
            rd_addr_a   = mem_addr(bank_ff, src2.idx);
            rd_addr_b   = mem_addr(bank_ff, src3.idx);
            rot_a_in    = src2.wrap;
            rot_b_in    = src3.wrap;
            state_in    = S_SH2;
         end

         // phase 2: fold taps 2 and 3, read tap 4
         S_SH2: begin
            unit_ctl.op = UNIT_MIX_O;
            o_in        = unit_word;
            rd_addr_a   = mem_addr(bank_ff, src4.idx);
            rot_a_in    = src4.wrap;
            if (idx_ff == IDX_W'(NUM_WORDS - 1)) begin
               state_in = S_SH_TAIL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SH0;
            end
         end

         // last word of the round, then the new bank goes live
         S_SH_TAIL: begin
            unit_ctl.op = UNIT_MIX_END;
            wr_en       = 1'b1;
            wr_addr     = mem_addr(~bank_ff, IDX_W'(NUM_WORDS - 1));
            bank_in     = ~bank_ff;
            idx_in      = '0;
            if (rounds_ff == ROUND_W'(1)) begin
               if (cmd_ff == CMD_DRAW) begin
                  wp_in    = '0;
                  br_in    = CNT_W'(WORD_W);
                  state_in = S_DRAW_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               rounds_in = rounds_ff - 1'b1;
               state_in  = S_SH0;
            end
         end

         S_DRAW_RD: begin
            if (br_ff == '0) begin
               // word used up: step on, shuffle after the last one
               if (wp_next >= IDX_W'(NUM_WORDS)) begin
                  rounds_in = ROUND_W'(1);
                  idx_in    = '0;
                  state_in  = S_SH0;
               end else begin
                  wp_in = wp_next;
                  br_in = CNT_W'(WORD_W);
               end
            end else begin
               rd_addr_a = mem_addr(bank_ff, wp_ff);
               state_in  = S_DRAW_TAKE;
            end
         end

         // take the top bits of the word and shift them out
         S_DRAW_TAKE: begin
            unit_ctl.op     = UNIT_TAKE;
            unit_ctl.rot_a  = 1'b0;
            unit_ctl.amount = take_k;
            // a draw that runs past the word leaves its last bits in place
            wr_en           = (need_ff == take_k);
            wr_addr         = mem_addr(bank_ff, wp_ff);
            val_in          = unit_val;
            br_in           = br_ff - take_k;
            need_in         = need_ff - take_k;
            state_in        = (need_ff == take_k) ? S_EMIT : S_DRAW_RD;
         end

         S_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = val_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // reset runs the fill and one shuffle as an empty seed
         state_ff      <= S_FILL;
         bank_ff       <= 1'b0;
         wp_ff         <= '0;
         br_ff         <= CNT_W'(WORD_W);
         sp_ff         <= '0;
         seeding_ff    <= 1'b0;
         idx_ff        <= '0;
         rounds_ff     <= ROUND_W'(1);
         rot_a_ff      <= 1'b0;
         rot_b_ff      <= 1'b0;
         cmd_ff        <= CMD_SEED;
         last_ff       <= 1'b1;
         empty_ff      <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_ff       <= bank_in;
         wp_ff         <= wp_in;
         br_ff         <= br_in;
         sp_ff         <= sp_in;
         seeding_ff    <= seeding_in;
         idx_ff        <= idx_in;
         rounds_ff     <= rounds_in;
         rot_a_ff      <= rot_a_in;
         rot_b_ff      <= rot_b_in;
         cmd_ff        <= cmd_in;
         last_ff       <= last_in;
         empty_ff      <= empty_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      need_ff      <= need_in;
      byte_ff      <= byte_in;
      val_ff       <= val_in;
      x_ff         <= x_in;
      o_ff         <= o_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // draw pointer stays on every fourth word inside the bank
   assert property (@(posedge clock) disable iff (reset)
      (wp_ff % IDX_W'(WORD_STEP) == '0) && (wp_ff < IDX_W'(NUM_WORDS)))
      else $error("draw pointer off its word grid");

   // bits owed only matter while a draw walks the words
   assert property (@(posedge clock) disable iff (reset)
      (br_ff <= CNT_W'(WORD_W)) &&
      ((state_ff != S_DRAW_RD && state_ff != S_DRAW_TAKE) || (need_ff <= CNT_W'(WORD_W))))
      else $error("bit counters out of range");

   assert property (@(posedge clock) disable iff (reset)
      sp_ff < POS_W'(SEED_BYTES))
      else $error("seed position past the state");

   // a result appears only out of the emit step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside emit");

   // each finished round swaps the live bank
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_TAIL) |=> (bank_ff != $past(bank_ff)))
      else $error("shuffle round did not swap banks");

endmodule

/* tb/cabg_stream_checker.sv */
`timescale 1ns / 100ps

module cabg_stream_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [cabg_pkg::REQ_DATA_W-1:0]   req_tdata,   // bit_count[6:0], seed_byte[14:7], zero
   input  logic [cabg_pkg::REQ_USER_W-1:0]   req_tuser,   // cmd[0], seed_empty[1]
   input  logic                              req_tlast,   // seed_last
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [cabg_pkg::WORD_W-1:0]       rsp_tdata,   // random_value[63:0]
   output int                                error_count,
   output int                                pending_draws,
   output int                                draws_checked
);
   import cabg_pkg::*;

   localparam int CA_WORDS        = 80;
   localparam int SPILL_WORDS     = 52;
   localparam int SEED_SPAN       = 640;
   localparam int SEED_MIX_ROUNDS = 197;

   localparam logic [63:0] BASE_TABLE [CA_WORDS] = '{
      64'ha888f71022e181bd, 64'h2385a85e36087989, 64'h20ff49270ec954cf, 64'ha68f432825ff749b,
      64'h87bfabfaee5c4d9e, 64'h0fc0d678d213f99c, 64'h439271a5c7c22777, 64'habe5acb9642a8103,
      64'h5c17a5228613598d, 64'h89de293826b2a148, 64'h4454535aec23e7c6, 64'h7226cb254a47cbc6,
      64'hba8b66c3835aad7e, 64'hfb59214b81d4a98c, 64'he62dc0746ad746be, 64'hd1f4194ecb6cd9d5,
      64'h78701f81f42c1948, 64'h8fccc9aaea1b68e9, 64'h464adfa0a258c07d, 64'h0f1f3ed907b3c47d,
      64'h8dec694af72add42, 64'hbfee489c7e8ef175, 64'hbfa60a9c4435876e, 64'h0452d611c7f055da,
      64'h8c8f3854e3fa1448, 64'h9e83bfb8c0b0e837, 64'ha942abdb2d91d070, 64'h6f52de0bf1e47693,
      64'h34c4d38ad1212667, 64'h4b06768ef21391bd, 64'h8e1412e997c9a8fd, 64'h50bfda09377ea28a,
      64'h078800b5470871ea, 64'ha9aaa916da96c5fb, 64'h22152498eca9c50a, 64'h6c51da24b87250b0,
      64'h1d46e78f65a2ef55, 64'h2da0d6c791de8be7, 64'h90295517bc846686, 64'h998a54e3218ac814,
      64'hd3ec5836257b96f8, 64'h19908f7cac6a00f5, 64'hfaa481ec4c16019c, 64'h97e6398dd5dee075,
      64'h48475ccfba79d982, 64'hd6a1062d4f3bcd4c, 64'h87a0959ece65f509, 64'h6719e57ed6ede60d,
      64'hf648daa575d9c6f7, 64'he5bb2da9c118e114, 64'haaebc6474fc5a834, 64'h874dcaf472a76dfc,
      64'h56309d44ddfa7109, 64'h9001cac5d3254553, 64'ha46727129321f695, 64'h357e1feae487b4b8,
      64'hdf6d1e1461a5876f, 64'h36fe3f03e1620147, 64'h3bb292e092dbec1e, 64'h04b054997f76a743,
      64'hd4629048376cb213, 64'h06f9bcb003bf6f82, 64'h5d36b34645d974d9, 64'h91a12bd764896c61,
      64'h6646abd7f82ff67f, 64'h90447798b42b05c7, 64'hbc10e5e87050f778, 64'h9ab994748afd5155,
      64'h05fe8ae3c32bb299, 64'hdfd34d860ea09cca, 64'hb99a9896a7dc966d, 64'h9f12f07a7dbb9ec7,
      64'he1a3bb6258d768e0, 64'h8a580cc45515cf7d, 64'h160c96cc71849d40, 64'h66c6624197f3d708,
      64'hb1acb50934546050, 64'hae0236b997921d2a, 64'hf632a828b5ef628e, 64'h14e8210276047ffa
   };

   // predicted automaton state
   logic [63:0] ca [CA_WORDS];
   int          word_at;
   int          bits_left;
   int          seed_at;
   bit          in_seed_run;
   logic [63:0] expected_draws [$];

   function automatic void load_base();
      for (int i = 0; i < CA_WORDS; i++) ca[i] = BASE_TABLE[i];
   endfunction

   // one automaton generation over the whole state
   function automatic void mix_state();
      logic [63:0] ext [CA_WORDS + SPILL_WORDS];
      for (int i = 0; i < CA_WORDS; i++) ext[i] = ca[i];
      for (int i = 0; i < SPILL_WORDS; i++) ext[CA_WORDS + i] = {ca[i][62:0], ca[i][63]};
      for (int i = 0; i < CA_WORDS; i++)
         ca[i] = ~((ext[i + 52] | ext[i + 12] | ext[i + 29]) ^ ext[i] ^ ext[i + 5]);
   endfunction

   function automatic void advance_word();
      word_at += 4;
      if (word_at >= CA_WORDS) begin
         mix_state();
         word_at = 0;
      end
      bits_left = 64;
   endfunction

   // msb-first bit take; shifts of 64 give zero in sv as well
   function automatic logic [63:0] take_bits(int n);
      logic [63:0] r;
      int          rest;
      if (bits_left == 0) advance_word();
      if (bits_left >= n) begin
         bits_left -= n;
         r = ca[word_at] >> (64 - n);
         ca[word_at] = ca[word_at] << n;
         return r;
      end
      rest = n - bits_left;
      r = ca[word_at] >> (64 - bits_left);
      advance_word();
      bits_left = 64 - rest;
      r = (r << rest) | (ca[word_at] >> (64 - rest));
      ca[word_at] = ca[word_at] << rest;
      return r;
   endfunction

   function automatic void absorb_seed(logic [7:0] sbyte, logic last, logic empty);
      bit opening;
      int rounds;
      opening = !in_seed_run;
      if (opening) begin
         load_base();
         word_at     = 0;
         bits_left   = 64;
         seed_at     = 0;
         in_seed_run = 1'b1;
      end
      if (!(last && empty)) begin
         ca[seed_at / 8] ^= {56'd0, sbyte} << (8 * (seed_at % 8));
         seed_at = (seed_at + 1 == SEED_SPAN) ? 0 : seed_at + 1;
      end
      if (last) begin
         rounds = (empty && opening) ? 1 : SEED_MIX_ROUNDS;
         repeat (rounds) mix_state();
         in_seed_run = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      int          cnt;
      logic [63:0] want;
      if (reset) begin
         load_base();
         mix_state();
         word_at     = 0;
         bits_left   = 64;
         seed_at     = 0;
         in_seed_run = 1'b0;
         expected_draws.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            cnt = int'(req_tdata[6:0]);
            if (req_tuser[0] == CMD_DRAW) begin
               if (cnt == 0) expected_draws.push_back(64'd0);
               else expected_draws.push_back(take_bits(cnt > 64 ? 64 : cnt));
            end else begin
               absorb_seed(req_tdata[14:7], req_tlast, req_tuser[1]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_draws.size() == 0) begin
               $error("random_value: no draw outstanding, got %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_draws.pop_front();
               draws_checked++;
               if (rsp_tdata !== want) begin
                  $error("random_value: expected %h, got %h", want, rsp_tdata);
                  error_count++;
               end
            end
         end
      end
      pending_draws <= expected_draws.size();
   end

endmodule

/* tb/tb_cellular_automaton_bit_generator.sv */
`timescale 1ns / 100ps

module tb_cellular_automaton_bit_generator;
   import cabg_pkg::*;

   // generous ceiling: each seed run pays its full shuffle rounds at the last byte
   localparam int LIMIT_CYCLES = 6_000_000;
   // long receiver hold-off to back the block up into its input
   localparam int HOLD_CYCLES  = 400;
   // drain margin after the last expected item, covers a shuffle in flight
   localparam int DRAIN_CYCLES = 300;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;    // bit_count[6:0], seed_byte[14:7], zero
   logic [REQ_USER_W-1:0]   req_tuser  = '0;    // cmd[0], seed_empty[1]
   logic                    req_tlast  = 1'b0;  // seed_last
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [WORD_W-1:0]       rsp_tdata;          // random_value[63:0]

   int error_count;
   int pending_draws;
   int draws_checked;

   // idle control: sender gap odds owned by the stimulus, stall odds read by the receiver
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;

   // run statistics for the summary
   int items_sent  = 0;
   int draws_sent  = 0;
   int seed_items  = 0;
   int seed_runs   = 0;

   always #6 clock = ~clock;

   cellular_automaton_bit_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cabg_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_draws (pending_draws),
      .draws_checked (draws_checked)
   );

   // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
   initial begin : receiver
      int hold_left;
      int holds_taken;
      hold_left   = 0;
      holds_taken = 0;
      forever begin
         @(posedge clock);
         if (holds_taken != hold_requests) begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("Regression FAIL");
      $finish;
   end

   // offer one item; valid stays high into the next item unless a gap is drawn
   task automatic offer(logic cmd, logic [6:0] cnt, logic [7:0] sbyte, logic last,
                        logic empty);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, sbyte, cnt};
      req_tuser  <= {empty, cmd};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (cmd == CMD_DRAW) draws_sent++;
      else seed_items++;
   endtask

   // draw sizes lean on the word edges: zero, oversized, full word, any
   function automatic logic [6:0] pick_count();
      int k;
      k = $urandom_range(99);
      if (k < 4) return 7'd0;
      if (k < 10) return 7'($urandom_range(127, 65));
      if (k < 20) return 7'd64;
      return 7'($urandom_range(64, 1));
   endfunction

   // seed run of len bytes then a closing item; draws slip in now and then,
   // and seed_empty without last rides along on some bytes
   task automatic seed_run(int len, bit empty_end);
      for (int j = 0; j < len; j++) begin
         if ($urandom_range(9) == 0)
            offer(CMD_DRAW, pick_count(), 8'($urandom), 1'($urandom), 1'($urandom));
         offer(CMD_SEED, 7'($urandom), 8'($urandom), 1'b0, $urandom_range(4) == 0);
      end
      offer(CMD_SEED, 7'($urandom), 8'($urandom), 1'b1, empty_end);
      seed_runs++;
   endtask

   // mostly draws with don't-care fields randomized, rare seed runs and empty seeds
   task automatic random_traffic(int n);
      int start;
      int r;
      start = items_sent;
      while (items_sent - start < n) begin
         r = $urandom_range(999);
         if (r < 5) seed_run($urandom_range(12), $urandom_range(3) == 0);
         else if (r < 12) offer(CMD_SEED, 7'($urandom), 8'($urandom), 1'b1, 1'b1);
         else offer(CMD_DRAW, pick_count(), 8'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: word edges, zero and oversized counts
      offer(CMD_DRAW, 7'd64,  8'h00, 1'b0, 1'b0);
      offer(CMD_DRAW, 7'd1,   8'hff, 1'b1, 1'b1);
      offer(CMD_DRAW, 7'd0,   8'h00, 1'b0, 1'b0);
      offer(CMD_DRAW, 7'd127, 8'hff, 1'b0, 1'b0);
      offer(CMD_DRAW, 7'd65,  8'h00, 1'b0, 1'b0);
      offer(CMD_DRAW, 7'd63,  8'h00, 1'b0, 1'b0);
      offer(CMD_DRAW, 7'd2,   8'h00, 1'b0, 1'b0);
      // empty seed as the only item: one shuffle, byte ignored
      offer(CMD_SEED, 7'd0,   8'hff, 1'b1, 1'b1);
      offer(CMD_DRAW, 7'd64,  8'h00, 1'b0, 1'b0);
      // seed run: plain byte, seed_empty without last, a draw mid-run,
      // then an empty close after bytes were taken (full seed rounds)
      offer(CMD_SEED, 7'h7f,  8'h00, 1'b0, 1'b0);
      offer(CMD_SEED, 7'd0,   8'hff, 1'b0, 1'b1);
      offer(CMD_DRAW, 7'd40,  8'hff, 1'b1, 1'b1);
      offer(CMD_SEED, 7'd0,   8'h5a, 1'b0, 1'b0);
      offer(CMD_SEED, 7'd0,   8'ha5, 1'b1, 1'b1);
      offer(CMD_DRAW, 7'd64,  8'h00, 1'b0, 1'b0);
      offer(CMD_DRAW, 7'd17,  8'h00, 1'b0, 1'b0);
      // one-byte seed
      offer(CMD_SEED, 7'd0,   8'h81, 1'b1, 1'b0);
      offer(CMD_DRAW, 7'd64,  8'h00, 1'b0, 1'b0);
      offer(CMD_DRAW, 7'd64,  8'h00, 1'b0, 1'b0);
      seed_runs += 3;

      // seed longer than 640 bytes so the byte position wraps
      for (int j = 0; j < 650; j++) offer(CMD_SEED, 7'($urandom), 8'($urandom), 1'b0, 1'b0);
      offer(CMD_SEED, 7'($urandom), 8'($urandom), 1'b1, 1'b0);
      seed_runs++;

      // no idling
      random_traffic(280);

      // sender idle most cycles
      send_idle_pct = 80;
      random_traffic(280);

      // receiver stalling most cycles
      send_idle_pct = 0;
      stall_pct    <= 80;
      random_traffic(280);

      // both sides idle now and then
      send_idle_pct = 19;
      stall_pct    <= 19;
      random_traffic(280);

      // back-pressure: receiver holds off while draws keep coming
      send_idle_pct  = 0;
      stall_pct     <= 0;
      hold_requests <= hold_requests + 1;
      repeat (60) offer(CMD_DRAW, pick_count(), 8'($urandom), 1'($urandom), 1'($urandom));

      // tail without idling, ends on draws so the drain is short
      random_traffic(200);
      repeat (4) offer(CMD_DRAW, pick_count(), 8'($urandom), 1'($urandom), 1'($urandom));
      req_tvalid <= 1'b0;

      // wait for every expected item, then a little longer for strays
      @(posedge clock);
      while (pending_draws != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items: %0d draws, %0d seed items over %0d seed runs",
               items_sent, draws_sent, seed_items, seed_runs);
      $display("checked %0d draw results under idle, stall and hold-off phases",
               draws_checked);
      if (error_count == 0 && pending_draws == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/cabg_pkg.sv
rtl/core/cabg_mem.sv
rtl/core/cabg_unit.sv
rtl/core/cellular_automaton_bit_generator.sv
tb/cabg_stream_checker.sv
tb/tb_cellular_automaton_bit_generator.sv
